### rtl/gtg_pkg.sv
// shared types and constants of the go-to-goal controller
`timescale 1ns / 1ps
package gtg_pkg;

  typedef logic signed [15:0] pos_t;
  typedef logic signed [15:0] angle_t;
  typedef logic [14:0] speed_t;
  typedef logic signed [19:0] rate_t;
  typedef logic [11:0] gain_t;

  localparam int TAB_LEN = 24;
  localparam int XW = 28;
  localparam int DIST_W = 18;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [17:0] PI_Q16 = 18'd205887;

  localparam gain_t GAIN_LIN_RST = 12'd256;
  localparam gain_t GAIN_ANG_RST = 12'd1024;
  localparam speed_t SPEED_CAP_RST = 15'd1536;
  localparam speed_t STOP_RADIUS_RST = 15'd31;

  localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

### rtl/gtg_if.sv
// pose and command channels of the go-to-goal controller
`timescale 1ns / 1ps
interface gtg_in_if import gtg_pkg::*; ();
  logic   valid;
  logic   ready;
  pos_t   cur_x;
  pos_t   cur_y;
  angle_t cur_heading;
  pos_t   goal_x;
  pos_t   goal_y;

  modport source (output valid, output cur_x, output cur_y, output cur_heading,
                  output goal_x, output goal_y, input ready);
  modport sink (input valid, input cur_x, input cur_y, input cur_heading,
                input goal_x, input goal_y, output ready);
endinterface

interface gtg_out_if import gtg_pkg::*; ();
  logic   valid;
  logic   ready;
  speed_t linear_speed;
  rate_t  angular_rate;
  logic   caught;

  modport source (output valid, output linear_speed, output angular_rate,
                  output caught, input ready);
  modport sink (input valid, input linear_speed, input angular_rate,
                input caught, output ready);
endinterface

### rtl/go_to_goal_controller.sv
// go-to-goal controller: pipelined cordic distance and bearing, proportional commands
`timescale 1ns / 1ps
// Takes one pose/goal item per clock while the pipeline is not held and returns one
// command item per item, in order, through one offset stage, one pre-rotation stage,
// one stage per cordic iteration, then gain scaling, two multiplier stages and the
// output register. The whole pipeline advances together and holds while the output
// register is full and not taken, so in_ch.ready is high when it is empty or taken.
// Gains, speed cap and stop radius sit in four APB registers at byte addresses 0, 4,
// 8, 12 and should only be written while no item is in flight.
module go_to_goal_controller import gtg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  gtg_in_if.sink      in_ch,
  gtg_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NSTEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int PW = XW + 17;

  typedef enum logic [1:0] {
    REG_GAIN_LIN   = 2'd0,
    REG_GAIN_ANG   = 2'd1,
    REG_SPEED_CAP  = 2'd2,
    REG_STOP_RAD   = 2'd3
  } reg_idx_t;

  // configuration registers
  gain_t  gain_lin_r, gain_ang_r;
  speed_t speed_cap_r, stop_rad_r;
  reg_idx_t cfg_idx;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_lin_r  <= GAIN_LIN_RST;
      gain_ang_r  <= GAIN_ANG_RST;
      speed_cap_r <= SPEED_CAP_RST;
      stop_rad_r  <= STOP_RADIUS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_GAIN_LIN:  gain_lin_r  <= cfg_pwdata[11:0];
        REG_GAIN_ANG:  gain_ang_r  <= cfg_pwdata[11:0];
        REG_SPEED_CAP: speed_cap_r <= cfg_pwdata[14:0];
        REG_STOP_RAD:  stop_rad_r  <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_LIN:  cfg_prdata = {20'd0, gain_lin_r};
      REG_GAIN_ANG:  cfg_prdata = {20'd0, gain_ang_r};
      REG_SPEED_CAP: cfg_prdata = {17'd0, speed_cap_r};
      REG_STOP_RAD:  cfg_prdata = {17'd0, stop_rad_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // pipeline enable
  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: offsets
  logic                a_valid_r;
  logic signed [16:0]  a_dx_r, a_dy_r;
  angle_t              a_head_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx_r   <= {in_ch.goal_x[15], in_ch.goal_x} - {in_ch.cur_x[15], in_ch.cur_x};
      a_dy_r   <= {in_ch.goal_y[15], in_ch.goal_y} - {in_ch.cur_y[15], in_ch.cur_y};
      a_head_r <= in_ch.cur_heading;
    end
  end

  // cordic stages, index 0 is the pre-rotated vector
  logic                 cv_r    [0:NSTEPS];
  logic signed [XW-1:0] cx_r    [0:NSTEPS];
  logic signed [XW-1:0] cy_r    [0:NSTEPS];
  logic [31:0]          cz_r    [0:NSTEPS];
  logic                 czero_r [0:NSTEPS];
  angle_t               chead_r [0:NSTEPS];

  logic signed [XW-1:0] dx_ext, dy_ext;
  logic                 a_neg;

  assign a_neg  = a_dx_r[16];
  assign dx_ext = {{(XW-17){a_dx_r[16]}}, a_dx_r};
  assign dy_ext = {{(XW-17){a_dy_r[16]}}, a_dy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]    <= (a_neg ? -dx_ext : dx_ext) <<< 8;
      cy_r[0]    <= (a_neg ? -dy_ext : dy_ext) <<< 8;
      cz_r[0]    <= a_neg ? 32'h8000_0000 : 32'h0000_0000;
      czero_r[0] <= (a_dx_r == 17'sd0) && (a_dy_r == 17'sd0);
      chead_r[0] <= a_head_r;
    end
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    assign xs = cy_r[k] >>> k;
    assign ys = cx_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy_r[k][XW-1]) begin
          cx_r[k+1] <= cx_r[k] + xs;
          cy_r[k+1] <= cy_r[k] - ys;
          cz_r[k+1] <= cz_r[k] + ATAN_TAB[k];
        end else begin
          cx_r[k+1] <= cx_r[k] - xs;
          cy_r[k+1] <= cy_r[k] + ys;
          cz_r[k+1] <= cz_r[k] - ATAN_TAB[k];
        end
        czero_r[k+1] <= czero_r[k];
        chead_r[k+1] <= chead_r[k];
      end
    end
  end

  // stage d: gain correction product and wrapped heading error
  logic                 d_valid_r;
  logic signed [PW-1:0] d_prod_r;
  logic signed [16:0]   d_e16_r;
  logic signed [XW-1:0] d_x;
  logic [31:0]          d_z, d_err;
  logic signed [32:0]   d_e33, d_esum;

  assign d_x    = czero_r[NSTEPS] ? '0 : cx_r[NSTEPS];
  assign d_z    = czero_r[NSTEPS] ? 32'd0 : cz_r[NSTEPS];
  assign d_err  = d_z - {chead_r[NSTEPS], 16'h0000};
  assign d_e33  = (d_err == 32'h8000_0000) ? 33'sh0_8000_0000 : {d_err[31], d_err};
  assign d_esum = d_e33 + 33'sd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      d_prod_r <= d_x * $signed({1'b0, INV_GAIN_Q16});
      d_e16_r  <= d_esum[32:16];
    end
  end

  // stage e: distance and first rate product
  logic                e_valid_r;
  logic [DIST_W-1:0]   e_dist_r;
  logic signed [29:0]  e_m1_r;
  logic signed [PW-1:0] e_round;

  assign e_round = d_prod_r + PW'(1 << 23);

  always_ff @(posedge clk) begin
    if (en) begin
      e_dist_r <= e_round[DIST_W+23:24];
      e_m1_r   <= $signed({1'b0, gain_ang_r}) * d_e16_r;
    end
  end

  // stage f: stop check, second rate product, speed product
  logic                f_valid_r;
  logic                f_caught_r;
  logic signed [48:0]  f_m2_r;
  logic [30:0]         f_sp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f_caught_r <= e_dist_r < {{(DIST_W-15){1'b0}}, stop_rad_r};
      f_m2_r     <= e_m1_r * $signed({1'b0, PI_Q16});
      f_sp_r     <= 31'(e_dist_r * gain_lin_r) + 31'd128;
    end
  end

  // output register
  logic signed [48:0] g_rsum;
  logic [22:0]        g_speed;
  speed_t             speed_r;
  rate_t              rate_r;
  logic               caught_r;

  assign g_rsum  = f_m2_r + 49'sd268435456;
  assign g_speed = f_sp_r[30:8];

  always_ff @(posedge clk) begin
    if (en) begin
      caught_r <= f_caught_r;
      if (f_caught_r) begin
        speed_r <= '0;
        rate_r  <= '0;
      end else begin
        speed_r <= (g_speed > {8'd0, speed_cap_r}) ? speed_cap_r : g_speed[14:0];
        rate_r  <= g_rsum[48:29];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= NSTEPS; j++) begin
        cv_r[j] <= 1'b0;
      end
    end else if (en) begin
      a_valid_r <= in_ch.valid;
      cv_r[0]   <= a_valid_r;
      for (int j = 0; j < NSTEPS; j++) begin
        cv_r[j+1] <= cv_r[j];
      end
      d_valid_r   <= cv_r[NSTEPS];
      e_valid_r   <= d_valid_r;
      f_valid_r   <= e_valid_r;
      out_valid_r <= f_valid_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.linear_speed = speed_r;
  assign out_ch.angular_rate = rate_r;
  assign out_ch.caught       = caught_r;

endmodule
